// ----- rtl/core/scale2x_pixel_upscaler_core_defines.svh -----
// ----------------------------------------------------------------------------
// Scale2x upscaler core - assertion macros
// Shared concurrent check macros, sampled on clock and masked during reset.
// ----------------------------------------------------------------------------
`ifndef SCALE2X_PIXEL_UPSCALER_CORE_DEFINES_SVH
`define SCALE2X_PIXEL_UPSCALER_CORE_DEFINES_SVH

// Check a property on every clock edge outside of reset.
`define SCL2X_ASSERT_NOW(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("scl2x check failed");

// Check that a cause on one edge is followed by an effect on the next edge.
`define SCL2X_ASSERT_NEXT(name, cause, effect) \
   name: assert property (@(posedge clock) disable iff (reset) ((cause) |=> (effect))) \
      else $error("scl2x sequence check failed");

`endif

// ----- rtl/core/scl2x_pkg.sv -----
// ----------------------------------------------------------------------------
// Scale2x upscaler package
// Shared widths, register indexes, block kinds, types and the Scale2x rule.
// ----------------------------------------------------------------------------
`default_nettype none

package scl2x_pkg;

   localparam int PIX_W          = 32;
   localparam int CFG_W          = 9;
   localparam int CSR_ADDR_W     = 1;
   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 9'd160;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 9'd144;

   localparam logic [CSR_ADDR_W-1:0] REG_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_FRAME_HEIGHT = 1'd1;

   typedef logic [2:0] blk_mask_type;

   // pending block kinds of one source pixel, in emission order
   localparam blk_mask_type BLK_UPPER = 3'b001;  // block of the row above
   localparam blk_mask_type BLK_LEFT  = 3'b010;  // last row, left neighbour
   localparam blk_mask_type BLK_LAST  = 3'b100;  // last row, own block at row end

   typedef logic [PIX_W-1:0] pixel_type;

   typedef struct packed {
      pixel_type e;
      pixel_type b;
      pixel_type d;
      pixel_type f;
      pixel_type h;
   } nbr_type;

   typedef struct packed {
      pixel_type bottom_right;
      pixel_type bottom_left;
      pixel_type top_right;
      pixel_type top_left;
   } quad_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } store_ctl_type;

   function automatic quad_type scale2x_rule(input nbr_type n);
      quad_type q;
      q.top_left     = n.e;
      q.top_right    = n.e;
      q.bottom_left  = n.e;
      q.bottom_right = n.e;
      if ((n.b != n.h) && (n.d != n.f)) begin
         if (n.d == n.b) q.top_left     = n.d;
         if (n.b == n.f) q.top_right    = n.f;
         if (n.d == n.h) q.bottom_left  = n.d;
         if (n.h == n.f) q.bottom_right = n.f;
      end
      return q;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/scale2x_pixel_upscaler_core.sv -----
// ----------------------------------------------------------------------------
// Scale2x pixel upscaler core
// Streams source pixels in raster order and emits one 2x2 Scale2x block each.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one 32-bit source pixel per beat, raster order, frame after frame.
//   rsp_*  : one 2x2 output block per beat with its source column and row;
//            rsp_tlast marks the final block of a frame.
//   csr_*  : write frame_width (index 0) or frame_height (index 1) while idle;
//            any write restarts the frame at column 0, row 0.
// Timing:
//   A pixel of row y carries out the block of row y-1 at the same column, so
//   row 0 produces nothing and blocks trail the input by one source row.
//   A pixel beat's first block passes the line-store read register, then the
//   output register. Throughput is one pixel per cycle while rsp_tready stays
//   high, on every row but the last; there each pixel after the first releases
//   two blocks (three on the frame's final pixel) through the single output
//   register, so the stage takes no new pixel until its last block issues.
// Reset and stall:
//   Reset restores 160x144, clears counters and drops all pending blocks; line
//   stores are not cleared, every entry is written before its value is used.
//   When rsp_tready is low the output register holds its beat, the working stage
//   holds its pixel and req_tready falls once that stage has a block pending.
// ----------------------------------------------------------------------------
`default_nettype none

`include "scale2x_pixel_upscaler_core_defines.svh"

module scale2x_pixel_upscaler_core #(
   parameter int MAX_WIDTH  = scl2x_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = scl2x_pkg::MAX_HEIGHT_DEF,
   parameter int XW         = $clog2(MAX_WIDTH),
   parameter int YW         = $clog2(MAX_HEIGHT),
   parameter int RSP_W      = ((XW + YW + 4 * scl2x_pkg::PIX_W + 7) / 8) * 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // source pixel channel
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [scl2x_pkg::PIX_W-1:0]         req_tdata,   // [31:0] pixel
   // output block channel
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // from bit 0: src_x, src_y, top_left, top_right, bottom_left, bottom_right
   output logic [RSP_W-1:0]                         rsp_tdata,
   output logic                                     rsp_tlast,   // frame_end
   // configuration write port
   input  wire logic                                csr_we,
   input  wire logic [scl2x_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [scl2x_pkg::CFG_W-1:0]         csr_wdata
);

   localparam int CFG_W = scl2x_pkg::CFG_W;
   localparam int WCW   = (XW + 1 > CFG_W) ? XW + 1 : CFG_W;
   localparam int HCW   = (YW + 1 > CFG_W) ? YW + 1 : CFG_W;

   // ------------------------------------------------------------------------
   // Configuration registers and effective frame size
   // ------------------------------------------------------------------------
   logic [CFG_W-1:0] frame_width_ff, frame_width_in;
   logic [CFG_W-1:0] frame_height_ff, frame_height_in;
   logic             restart;
   logic [WCW-1:0]   width_ext, eff_w;
   logic [HCW-1:0]   height_ext, eff_h;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      restart         = 1'b0;
      if (csr_we) begin
         unique case (csr_addr)
            scl2x_pkg::REG_FRAME_WIDTH: begin
               frame_width_in = csr_wdata;
               restart        = 1'b1;
            end
            scl2x_pkg::REG_FRAME_HEIGHT: begin
               frame_height_in = csr_wdata;
               restart         = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   // clamp to 2..MAX, the registers keep the written bits
   always_comb begin
      width_ext  = WCW'(frame_width_ff);
      height_ext = HCW'(frame_height_ff);
      if (width_ext < WCW'(2))               eff_w = WCW'(2);
      else if (width_ext > WCW'(MAX_WIDTH))  eff_w = WCW'(MAX_WIDTH);
      else                                   eff_w = width_ext;
      if (height_ext < HCW'(2))              eff_h = HCW'(2);
      else if (height_ext > HCW'(MAX_HEIGHT)) eff_h = HCW'(MAX_HEIGHT);
      else                                   eff_h = height_ext;
   end

   // ------------------------------------------------------------------------
   // Input side: position counters and bank select
   // ------------------------------------------------------------------------
   logic [XW-1:0] col_ff, col_in;
   logic [YW-1:0] row_ff, row_in;
   logic          sel_ff, sel_in;      // bank holding the previous row
   logic          accept;
   logic          row_end, last_row;
   logic          x_ge1, x_ge2, y_ge1, y_ge2;
   scl2x_pkg::blk_mask_type mask_now;

   assign accept   = req_tvalid && req_tready;
   assign row_end  = (WCW'(col_ff) + WCW'(1)) >= eff_w;
   assign last_row = (HCW'(row_ff) + HCW'(1)) >= eff_h;
   assign x_ge1    = col_ff != '0;
   assign x_ge2    = col_ff > XW'(1);
   assign y_ge1    = row_ff != '0;
   assign y_ge2    = row_ff > YW'(1);

   // the last row always has y >= 1 since height is at least 2
   assign mask_now = (y_ge1 ? scl2x_pkg::BLK_UPPER : '0)
                   | ((last_row && x_ge1) ? scl2x_pkg::BLK_LEFT : '0)
                   | ((last_row && row_end) ? scl2x_pkg::BLK_LAST : '0);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      sel_in = sel_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
         sel_in = 1'b0;
      end else if (accept) begin
         if (row_end) begin
            col_in = '0;
            if (last_row) begin
               row_in = '0;
               sel_in = 1'b0;
            end else begin
               row_in = row_ff + YW'(1);
               sel_in = ~sel_ff;
            end
         end else begin
            col_in = col_ff + XW'(1);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Line stores: two banks used ping-pong; sel_ff picks the previous row.
   // Write the current row at x, read the previous row at x and x+1 and the
   // row before it at x (before it is overwritten).
   // ------------------------------------------------------------------------
   scl2x_pkg::store_ctl_type bank_ctl [2];
   scl2x_pkg::pixel_type     rd_a [2];
   scl2x_pkg::pixel_type     rd_b [2];
   logic [XW-1:0]            addr_next;

   assign addr_next = col_ff + XW'(1);

   for (genvar k = 0; k < 2; k++) begin : g_bank
      assign bank_ctl[k].wr_en = accept && (sel_ff != 1'(k));
      assign bank_ctl[k].rd_en = accept;

      scl2x_line_store #(
         .DEPTH (MAX_WIDTH),
         .AW    (XW)
      ) u_store (
         .clock     (clock),
         .ctl       (bank_ctl[k]),
         .wr_addr   (col_ff),
         .wr_data   (req_tdata),
         .rd_addr_a (addr_next),
         .rd_addr_b (col_ff),
         .rd_data_a (rd_a[k]),
         .rd_data_b (rd_b[k])
      );
   end

   // ------------------------------------------------------------------------
   // Working stage: one pixel with its neighbours, up to three blocks pending
   // ------------------------------------------------------------------------
   logic                    s1_valid_ff, s1_valid_in;
   scl2x_pkg::pixel_type    s1_px_ff;
   logic [XW-1:0]           s1_x_ff;
   logic [YW-1:0]           s1_y_ff;
   logic                    s1_sel_ff, s1_has_b_ff, s1_x_ge1_ff, s1_x_ge2_ff, s1_has_f_ff;
   scl2x_pkg::blk_mask_type pend_ff, pend_in;
   scl2x_pkg::blk_mask_type pick;

   // history of the stage: previous pixel's upper neighbour and two last pixels
   scl2x_pkg::pixel_type    hist_e_ff, hist_e_in;
   scl2x_pkg::pixel_type    hist_px1_ff, hist_px1_in;
   scl2x_pkg::pixel_type    hist_px2_ff, hist_px2_in;

   scl2x_pkg::pixel_type    up_e, up_f, up_b;
   logic                    out_free, issue, done;

   assign up_e = s1_sel_ff ? rd_b[1] : rd_b[0];
   assign up_f = s1_sel_ff ? rd_a[1] : rd_a[0];
   assign up_b = s1_sel_ff ? rd_b[0] : rd_b[1];

   assign pick     = pend_ff & (~pend_ff + 3'd1);
   assign out_free = !rsp_tvalid || rsp_tready;
   assign issue    = s1_valid_ff && (pend_ff != '0) && out_free;
   assign done     = s1_valid_ff
                     && ((pend_ff == '0) || (issue && ((pend_ff & ~pick) == '0)));

   assign req_tready = !s1_valid_ff || done;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      pend_in     = pend_ff;
      hist_e_in   = hist_e_ff;
      hist_px1_in = hist_px1_ff;
      hist_px2_in = hist_px2_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         pend_in     = mask_now;
         // shift out the pixel that leaves the stage
         hist_e_in   = up_e;
         hist_px1_in = s1_px_ff;
         hist_px2_in = hist_px1_ff;
      end else begin
         if (done) s1_valid_in = 1'b0;
         if (issue) pend_in = pend_ff & ~pick;
      end
   end

   // ------------------------------------------------------------------------
   // Block selection and the Scale2x rule
   // ------------------------------------------------------------------------
   scl2x_pkg::nbr_type  nbr;
   scl2x_pkg::quad_type quad;
   logic [XW-1:0]       blk_x;
   logic [YW-1:0]       blk_y;
   logic                blk_last;

   always_comb begin
      nbr      = '0;
      blk_x    = s1_x_ff;
      blk_y    = s1_y_ff;
      blk_last = 1'b0;
      unique case (pick)
         scl2x_pkg::BLK_UPPER: begin
            nbr.e = up_e;
            nbr.b = s1_has_b_ff ? up_b : up_e;
            nbr.d = s1_x_ge1_ff ? hist_e_ff : up_e;
            nbr.f = s1_has_f_ff ? up_f : up_e;
            nbr.h = s1_px_ff;
            blk_y = s1_y_ff - YW'(1);
         end
         scl2x_pkg::BLK_LEFT: begin
            nbr.e = hist_px1_ff;
            nbr.b = hist_e_ff;
            nbr.d = s1_x_ge2_ff ? hist_px2_ff : hist_px1_ff;
            nbr.f = s1_px_ff;
            nbr.h = hist_px1_ff;
            blk_x = s1_x_ff - XW'(1);
         end
         scl2x_pkg::BLK_LAST: begin
            nbr.e    = s1_px_ff;
            nbr.b    = up_e;
            nbr.d    = hist_px1_ff;
            nbr.f    = s1_px_ff;
            nbr.h    = s1_px_ff;
            blk_last = 1'b1;
         end
         default: begin
            nbr = '0;
         end
      endcase
   end

   assign quad = scl2x_pkg::scale2x_rule(nbr);

   // ------------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------------
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (issue) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({quad, blk_y, blk_x});
         rsp_last_in  = blk_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= scl2x_pkg::WIDTH_RESET;
         frame_height_ff <= scl2x_pkg::HEIGHT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
         sel_ff          <= 1'b0;
         s1_valid_ff     <= 1'b0;
         pend_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         sel_ff          <= sel_in;
         s1_valid_ff     <= s1_valid_in;
         pend_ff         <= pend_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload: load the stage on a pixel beat, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff    <= req_tdata;
         s1_x_ff     <= col_ff;
         s1_y_ff     <= row_ff;
         s1_sel_ff   <= sel_ff;
         s1_has_b_ff <= y_ge2;
         s1_x_ge1_ff <= x_ge1;
         s1_x_ge2_ff <= x_ge2;
         s1_has_f_ff <= !row_end;
      end
      hist_e_ff   <= hist_e_in;
      hist_px1_ff <= hist_px1_in;
      hist_px2_ff <= hist_px2_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // ------------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------------
   `SCL2X_ASSERT_NOW(a_pend_needs_stage, (s1_valid_ff == 1'b0) |-> (pend_ff == '0))
   `SCL2X_ASSERT_NOW(a_pick_onehot, issue |-> $onehot(pick))
   `SCL2X_ASSERT_NOW(a_col_in_frame, (WCW'(col_ff) < eff_w) && (HCW'(row_ff) < eff_h))
   `SCL2X_ASSERT_NEXT(a_last_row_holds_input, accept && last_row && x_ge1, !req_tready)

endmodule

`default_nettype wire

// ----- rtl/core/scl2x_line_store.sv -----
// ----------------------------------------------------------------------------
// Scale2x line store
// One source row of pixels: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module scl2x_line_store #(
   parameter int DEPTH = scl2x_pkg::MAX_WIDTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic                    clock,
   input  wire scl2x_pkg::store_ctl_type ctl,
   input  wire logic [AW-1:0]           wr_addr,
   input  wire scl2x_pkg::pixel_type    wr_data,
   input  wire logic [AW-1:0]           rd_addr_a,
   input  wire logic [AW-1:0]           rd_addr_b,
   output scl2x_pkg::pixel_type         rd_data_a,
   output scl2x_pkg::pixel_type         rd_data_b
);

   scl2x_pkg::pixel_type store_ff [DEPTH];
   scl2x_pkg::pixel_type rd_a_ff;
   scl2x_pkg::pixel_type rd_b_ff;

   // reads return the old word when they hit the address being written
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_a_ff <= store_ff[rd_addr_a];
         rd_b_ff <= store_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

// ----- bench/scale2x_pixel_upscaler_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scale2x pixel upscaler core - self-checking testbench
// Streams source frames of many sizes into the core, predicts every 2x2 block
// from a local line-store model and checks each output beat field by field.
// ----------------------------------------------------------------------------

module scale2x_pixel_upscaler_core_tb;

   import scl2x_pkg::*;

   localparam int MAXW       = MAX_WIDTH_DEF;
   localparam int MAXH       = MAX_HEIGHT_DEF;
   localparam int RSP_BITS   = ((8 + 8 + 4 * PIX_W + 7) / 8) * 8;
   localparam int RANDOM_PIX = 220;
   localparam int HOLD_AFTER = 100;   // blocks seen before the long receiver hold
   localparam int HOLD_LEN   = 400;   // cycles of that hold
   localparam int SETTLE_CYC = 10;    // covers pixels in flight that make no block

   // one expected or observed output block
   typedef struct packed {
      logic [7:0] src_x;
      logic [7:0] src_y;
      pixel_type  top_left;
      pixel_type  top_right;
      pixel_type  bottom_left;
      pixel_type  bottom_right;
      logic       frame_end;
   } out_block_t;

   // directed stimulus: either a size register write or a source pixel;
   // fill, where set, is the value every corner of every block it causes must have
   typedef enum logic {ROW_CSR, ROW_PIXEL} row_kind_e;

   typedef struct packed {
      row_kind_e                 kind;
      logic [CSR_ADDR_W-1:0]     idx;
      logic [31:0]               value;
      logic                      has_fill;
      pixel_type                 fill;
   } stim_row_t;

   localparam stim_row_t DIRECTED [25] = '{
      // widths and heights below 2 clamp to a 2x2 frame
      '{ROW_CSR,   REG_FRAME_WIDTH,  32'd0,        1'b0, 32'h0},
      '{ROW_CSR,   REG_FRAME_HEIGHT, 32'd1,        1'b0, 32'h0},
      // uniform frame of all ones: every corner is the source pixel
      '{ROW_PIXEL, REG_FRAME_WIDTH,  32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
      // uniform frame of all zeros
      '{ROW_PIXEL, REG_FRAME_WIDTH,  32'h00000000, 1'b1, 32'h00000000},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  32'h00000000, 1'b1, 32'h00000000},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  32'h00000000, 1'b1, 32'h00000000},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  32'h00000000, 1'b1, 32'h00000000},
      // checkerboard with out-of-frame neighbours
      '{ROW_PIXEL, REG_FRAME_WIDTH,  32'h12345678, 1'b0, 32'h0},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  32'h9ABCDEF0, 1'b0, 32'h0},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  32'h9ABCDEF0, 1'b0, 32'h0},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  32'h12345678, 1'b0, 32'h0},
      // 3x3 frame whose center takes its neighbours on two corners
      '{ROW_CSR,   REG_FRAME_WIDTH,  32'd3,        1'b0, 32'h0},
      '{ROW_CSR,   REG_FRAME_HEIGHT, 32'd3,        1'b0, 32'h0},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  32'h11111111, 1'b0, 32'h0},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  32'h22222222, 1'b0, 32'h0},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  32'h33333333, 1'b0, 32'h0},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  32'h22222222, 1'b0, 32'h0},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  32'h55555555, 1'b0, 32'h0},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  32'h33333333, 1'b0, 32'h0},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  32'h44444444, 1'b0, 32'h0},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  32'h33333333, 1'b0, 32'h0},
      '{ROW_PIXEL, REG_FRAME_WIDTH,  32'h66666666, 1'b0, 32'h0}
   };

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   pixel_type               req_tdata   = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic [RSP_BITS-1:0]     rsp_tdata;
   logic                    rsp_tlast;
   logic                    csr_we      = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_addr    = REG_FRAME_WIDTH;
   logic [CFG_W-1:0]        csr_wdata   = '0;

   // shadow of the core: size registers, line-store banks and frame position
   logic [CFG_W-1:0]  width_reg   = WIDTH_RESET;
   logic [CFG_W-1:0]  height_reg  = HEIGHT_RESET;
   pixel_type         line_bank [0:1][0:MAXW-1];
   int unsigned       col_pos     = 0;
   int unsigned       row_pos     = 0;
   logic              prev_bank   = 1'b0;
   pixel_type         last_pixel  = '0;

   out_block_t        expected_blocks [$];
   pixel_type         palette [4];
   int unsigned       fault_count = 0;
   int unsigned       blocks_seen = 0;
   logic              steady_flow = 1'b0;   // set: neither side idles

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   scale2x_pixel_upscaler_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // --------------------------------------------------------------------------
   // Prediction
   // --------------------------------------------------------------------------

   // register value clamped to the range the core can scan
   function automatic int unsigned effective_dim(input logic [CFG_W-1:0] v,
                                                 input int unsigned hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return v;
   endfunction

   // apply the Scale2x corner rule and queue the block;
   // a typed-in fill replaces the computed corners
   function automatic void queue_block(input int unsigned x, input int unsigned y,
                                       input pixel_type e, input pixel_type b,
                                       input pixel_type d, input pixel_type f,
                                       input pixel_type h, input logic last,
                                       input logic has_fill, input pixel_type fill);
      out_block_t blk;
      blk.src_x        = x[7:0];
      blk.src_y        = y[7:0];
      blk.top_left     = e;
      blk.top_right    = e;
      blk.bottom_left  = e;
      blk.bottom_right = e;
      blk.frame_end    = last;
      if (b != h && d != f) begin
         if (d == b) blk.top_left     = d;
         if (b == f) blk.top_right    = f;
         if (d == h) blk.bottom_left  = d;
         if (h == f) blk.bottom_right = f;
      end
      if (has_fill) begin
         blk.top_left     = fill;
         blk.top_right    = fill;
         blk.bottom_left  = fill;
         blk.bottom_right = fill;
      end
      expected_blocks.push_back(blk);
   endfunction

   // blocks released by one accepted source pixel, in emission order
   function automatic void predict_blocks_for_pixel(input pixel_type px,
                                                    input logic has_fill,
                                                    input pixel_type fill);
      int unsigned w, h, x, y;
      logic        pb, cb;
      pixel_type   e, b, d, f;
      w  = effective_dim(width_reg, MAXW);
      h  = effective_dim(height_reg, MAXH);
      x  = col_pos;
      y  = row_pos;
      pb = prev_bank;
      cb = ~prev_bank;
      if (y >= 1) begin
         // block of the row above, this pixel is its lower neighbour
         e = line_bank[pb][x];
         b = (y >= 2) ? line_bank[cb][x] : e;
         d = (x >= 1) ? line_bank[pb][x-1] : e;
         f = (x + 1 < w) ? line_bank[pb][x+1] : e;
         queue_block(x, y - 1, e, b, d, f, px, 1'b0, has_fill, fill);
         if (y + 1 >= h) begin
            // last row: the left pixel now knows its right neighbour
            if (x >= 1) begin
               e = last_pixel;
               b = line_bank[pb][x-1];
               d = (x >= 2) ? line_bank[cb][x-2] : e;
               queue_block(x - 1, y, e, b, d, px, e, 1'b0, has_fill, fill);
            end
            if (x + 1 >= w)
               queue_block(x, y, px, line_bank[pb][x], last_pixel, px, px, 1'b1,
                           has_fill, fill);
         end
      end
      line_bank[cb][x] = px;
      last_pixel       = px;
      if (x + 1 >= w) begin
         col_pos = 0;
         if (y + 1 >= h) begin
            row_pos   = 0;
            prev_bank = 1'b0;
         end else begin
            row_pos   = y + 1;
            prev_bank = cb;
         end
      end else begin
         col_pos = x + 1;
      end
   endfunction

   // --------------------------------------------------------------------------
   // Stimulus helpers
   // --------------------------------------------------------------------------

   function automatic void report_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) $display("%s", msg);
   endfunction

   // offer one pixel beat, idling at random first; predict once accepted
   task automatic push_pixel(input pixel_type px, input logic has_fill,
                             input pixel_type fill);
      while (!steady_flow && $urandom_range(0, 99) < 38) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      do @(posedge clock); while (!req_tready);
      predict_blocks_for_pixel(px, has_fill, fill);
   endtask

   // drop valid, wait for every expected block, then let in-flight pixels retire
   task automatic settle_core();
      req_tvalid <= 1'b0;
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   // any write restarts the frame at column 0, row 0 with the first bank
   task automatic write_size_register(input logic [CSR_ADDR_W-1:0] idx,
                                      input logic [CFG_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == REG_FRAME_WIDTH) width_reg = value;
      else if (idx == REG_FRAME_HEIGHT) height_reg = value;
      col_pos   = 0;
      row_pos   = 0;
      prev_bank = 1'b0;
      @(posedge clock);
   endtask

   function automatic void refresh_palette();
      foreach (palette[i]) palette[i] = $urandom();
   endfunction

   // mostly a small palette so neighbours compare equal, else extremes and noise
   function automatic pixel_type pick_pixel();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 75) return palette[$urandom_range(0, 3)];
      if (r < 80) return '0;
      if (r < 85) return '1;
      return $urandom();
   endfunction

   // mostly tiny frames, some clamped below 2, a few medium ones
   function automatic logic [CFG_W-1:0] pick_dim();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 7) return CFG_W'($urandom_range(2, 6));
      if (r < 8) return CFG_W'($urandom_range(0, 1));
      return CFG_W'($urandom_range(7, 16));
   endfunction

   task automatic stream_pixels(input int unsigned count);
      repeat (count) push_pixel(pick_pixel(), 1'b0, '0);
   endtask

   // --------------------------------------------------------------------------
   // Output side: random backpressure, one long hold, beat checking
   // --------------------------------------------------------------------------

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got)
         report_fault($sformatf("block %0d %s: expected %h, got %h",
                                blocks_seen, name, want, got));
   endtask

   task automatic check_block_beat();
      out_block_t want, got;
      got.src_x        = rsp_tdata[7:0];
      got.src_y        = rsp_tdata[15:8];
      got.top_left     = rsp_tdata[47:16];
      got.top_right    = rsp_tdata[79:48];
      got.bottom_left  = rsp_tdata[111:80];
      got.bottom_right = rsp_tdata[143:112];
      got.frame_end    = rsp_tlast;
      blocks_seen++;
      if (expected_blocks.size() == 0) begin
         report_fault($sformatf("block %0d at x %0d y %0d with none expected",
                                blocks_seen, got.src_x, got.src_y));
         return;
      end
      want = expected_blocks.pop_front();
      compare_field("src_x",        want.src_x,        got.src_x);
      compare_field("src_y",        want.src_y,        got.src_y);
      compare_field("top_left",     want.top_left,     got.top_left);
      compare_field("top_right",    want.top_right,    got.top_right);
      compare_field("bottom_left",  want.bottom_left,  got.bottom_left);
      compare_field("bottom_right", want.bottom_right, got.bottom_right);
      compare_field("frame_end",    want.frame_end,    got.frame_end);
   endtask

   int unsigned hold_left = 0;
   logic        hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_block_beat();
         if (hold_left != 0) begin
            // keep holding off until the hold count runs out
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && blocks_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady_flow || ($urandom_range(0, 99) >= 38);
         end
      end
   end

   // --------------------------------------------------------------------------
   // Main sequence
   // --------------------------------------------------------------------------

   initial begin
      int unsigned random_sent;
      int unsigned frames;
      int unsigned frame_pix;
      int unsigned waited;
      random_sent = 0;
      refresh_palette();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: small frames, extremes and clamped sizes
      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].kind == ROW_CSR) begin
            settle_core();
            write_size_register(DIRECTED[i].idx, DIRECTED[i].value[CFG_W-1:0]);
         end else begin
            push_pixel(DIRECTED[i].value, DIRECTED[i].has_fill, DIRECTED[i].fill);
         end
      end

      // widest frame, two rows: all register bits set clamps to full width;
      // the long receiver hold lands in its last row
      settle_core();
      refresh_palette();
      write_size_register(REG_FRAME_WIDTH, 9'd511);
      write_size_register(REG_FRAME_HEIGHT, 9'd2);
      stream_pixels(MAXW * 2);

      // tallest frame, two columns, with no idling on either side
      settle_core();
      refresh_palette();
      write_size_register(REG_FRAME_WIDTH, 9'd2);
      write_size_register(REG_FRAME_HEIGHT, 9'd256);
      steady_flow <= 1'b1;
      stream_pixels(2 * MAXH);
      settle_core();
      steady_flow <= 1'b0;

      // oversized registers, frame cut off after the start of the second row
      refresh_palette();
      write_size_register(REG_FRAME_WIDTH, 9'd257);
      write_size_register(REG_FRAME_HEIGHT, 9'd511);
      stream_pixels(MAXW + 44);

      // random phases: new sizes, whole frames with random content,
      // sometimes a frame broken off by the next register write
      while (random_sent < RANDOM_PIX) begin
         settle_core();
         refresh_palette();
         case ($urandom_range(0, 3))
            0: write_size_register(REG_FRAME_WIDTH, pick_dim());
            1: write_size_register(REG_FRAME_HEIGHT, pick_dim());
            default: begin
               write_size_register(REG_FRAME_WIDTH, pick_dim());
               write_size_register(REG_FRAME_HEIGHT, pick_dim());
            end
         endcase
         frame_pix = effective_dim(width_reg, MAXW) * effective_dim(height_reg, MAXH);
         frames    = $urandom_range(0, 2);
         repeat (frames) begin
            stream_pixels(frame_pix);
            random_sent += frame_pix;
         end
         if (frames == 0 || $urandom_range(0, 2) == 0) begin
            frames = $urandom_range(1, frame_pix - 1);
            stream_pixels(frames);
            random_sent += frames;
         end
      end

      // wait out every expected block, then a little longer for strays
      req_tvalid <= 1'b0;
      for (waited = 0; waited < 50000 && expected_blocks.size() != 0; waited++)
         @(posedge clock);
      if (expected_blocks.size() != 0)
         report_fault($sformatf("%0d expected blocks never arrived",
                                expected_blocks.size()));
      repeat (20) @(posedge clock);
      if (fault_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // hang guard, far beyond the slowest correct run
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
